/* design/plsf_pkg.sv */
// ----------------------------------------------------------------------------
// plsf_pkg
// Shared constants and types of the polynomial least-squares fit core.
// ----------------------------------------------------------------------------
package plsf_pkg;

    // fixed field widths
    localparam int CFG_W     = 3;
    localparam int SAMPLE_W  = 16;
    localparam int FIT_W     = 16;
    localparam int PS_W      = 48;
    localparam int MOM_W     = 64;
    localparam int OP_W      = 64;
    localparam int Q_W       = 18;

    // parameter defaults
    localparam int DEF_MAX_TERMS = 4;
    localparam int DEF_MAX_LEN   = 64;

    // register reset value
    localparam logic [CFG_W-1:0] TERMS_RESET = 3'd2;

    // solve request from the accumulator side
    typedef struct packed {
        logic             start;
        logic [CFG_W-1:0] terms;
    } plsf_req_t;

    // solver status
    typedef struct packed {
        logic busy;
        logic done;
    } plsf_stat_t;

    // one result item
    typedef struct packed {
        logic [FIT_W-1:0] fitted;
        logic             last_res;
        logic             singular;
    } plsf_res_t;

endpackage

/* design/plsf_solve.sv */
// ----------------------------------------------------------------------------
// plsf_solve
// Exact Cramer solve of the normal equations and evaluation of the fit, all
// on one shared wide adder driven by a small sequencer.
// ----------------------------------------------------------------------------
module plsf_solve
    import plsf_pkg::*;
#(
    parameter int MAX_TERMS = DEF_MAX_TERMS,
    parameter int MAX_LEN   = DEF_MAX_LEN,
    localparam int NW   = $clog2(MAX_LEN + 1),
    localparam int CW   = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1,
    localparam int CIW  = $clog2(MAX_TERMS + 1)
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  plsf_req_t       req,
    input  logic [NW-1:0]   count,
    output plsf_stat_t      stat,
    output logic [CW-1:0]   rd_row,
    output logic [CIW-1:0]  rd_col,
    input  logic [OP_W-1:0] rd_data,
    output plsf_res_t       res,
    output logic            res_valid,
    input  logic            res_ready
);

    localparam int LIMBS = (75 * MAX_TERMS + 36) / 32 + 1;
    localparam int WW    = 32 * LIMBS;
    localparam int XW    = $clog2(MAX_LEN);
    localparam int MW    = NW + CFG_W;
    localparam int BCW   = $clog2(OP_W);
    localparam int QCW   = $clog2(Q_W);

    localparam logic [4:0] S_IDLE      = 5'd0;
    localparam logic [4:0] S_DET_INIT  = 5'd1;
    localparam logic [4:0] S_TUP_CHECK = 5'd2;
    localparam logic [4:0] S_MUL_LOAD  = 5'd3;
    localparam logic [4:0] S_MUL_RUN   = 5'd4;
    localparam logic [4:0] S_ACC       = 5'd5;
    localparam logic [4:0] S_TUP_NEXT  = 5'd6;
    localparam logic [4:0] S_DET_DONE  = 5'd7;
    localparam logic [4:0] S_X_INIT    = 5'd8;
    localparam logic [4:0] S_X_DIV     = 5'd9;
    localparam logic [4:0] S_EVAL      = 5'd10;
    localparam logic [4:0] S_HOR_ADD   = 5'd11;
    localparam logic [4:0] S_ABS_NUM   = 5'd12;
    localparam logic [4:0] S_ABS_DEN   = 5'd13;
    localparam logic [4:0] S_R_ADD     = 5'd14;
    localparam logic [4:0] S_DIV_RUN   = 5'd15;
    localparam logic [4:0] S_DIV_CHK   = 5'd16;
    localparam logic [4:0] S_EMIT      = 5'd17;

    logic [4:0]       state_reg, state_next;
    logic [CFG_W-1:0] p_reg, p_next;
    logic [NW-1:0]    n_reg, n_next;
    logic [CIW-1:0]   rep_reg, rep_next;
    logic [CW-1:0]    tuple_reg [MAX_TERMS];
    logic [CW-1:0]    tuple_next [MAX_TERMS];
    logic [CW-1:0]    tup_inc [MAX_TERMS];
    logic [CIW-1:0]   row_reg, row_next;
    logic [WW-1:0]    prod_reg, prod_next;
    logic [WW-1:0]    macc_reg, macc_next;
    logic [WW-1:0]    mcand_reg, mcand_next;
    logic [WW-1:0]    det_reg, det_next;
    logic [OP_W-1:0]  op_reg, op_next;
    logic [BCW-1:0]   bit_reg, bit_next;
    logic [WW-1:0]    dets_reg [MAX_TERMS];
    logic [WW-1:0]    den_reg, den_next;
    logic             dets_we;
    logic [CIW-1:0]   k_reg, k_next;
    logic [XW-1:0]    x_reg, x_next;
    logic [MW-1:0]    rem_reg, rem_next;
    logic [CIW-1:0]   j_reg, j_next;
    logic             hor_reg, hor_next;
    logic [WW-1:0]    r_reg, r_next;
    logic [WW-1:0]    b_reg, b_next;
    logic [WW-1:0]    dd_reg, dd_next;
    logic [Q_W-1:0]   q_reg, q_next;
    logic [QCW-1:0]   qc_reg, qc_next;
    logic             neg_reg, neg_next;
    logic [FIT_W-1:0] fit_reg, fit_next;
    logic             sing_reg, sing_next;

    logic [WW-1:0]    add_a, add_b;
    logic             add_cin;
    logic [WW:0]      add_sum;
    logic             perm_ok, perm_odd, tup_wrap;
    logic [CW-1:0]    hor_idx;
    logic [WW-1:0]    det_rd;
    logic             den_zero;
    logic [Q_W-1:0]   qf;
    logic [CFG_W-1:0] p_clamp;
    logic [CW-1:0]    col_digit;

    // shared wide adder
    assign add_sum = {1'b0, add_a} + {1'b0, add_b} + {{WW{1'b0}}, add_cin};

    // column lookup for the entry being read
    assign col_digit = tuple_reg[row_reg[CW-1:0]];
    assign rd_row    = row_reg[CW-1:0];
    assign rd_col    = (CIW'(col_digit) == rep_reg) ? CIW'(MAX_TERMS) : CIW'(col_digit);

    // determinant read port
    assign hor_idx  = (state_reg == S_EVAL) ? CW'(p_reg - CFG_W'(1))
                                            : CW'(j_reg - CIW'(1));
    assign det_rd   = dets_reg[hor_idx];
    assign den_zero = (den_reg == '0);

    // clamped term count
    assign p_clamp = (req.terms == '0) ? CFG_W'(1) :
                     ((req.terms > CFG_W'(MAX_TERMS)) ? CFG_W'(MAX_TERMS) : req.terms);

    // permutation check and parity over the active digits
    always_comb
    begin
        perm_ok  = 1'b1;
        perm_odd = 1'b0;
        for (int a = 0; a < MAX_TERMS; a++)
        begin
            for (int b = a + 1; b < MAX_TERMS; b++)
            begin
                if (b < int'(p_reg))
                begin
                    if (tuple_reg[a] == tuple_reg[b])
                        perm_ok = 1'b0;
                    if (tuple_reg[a] > tuple_reg[b])
                        perm_odd = ~perm_odd;
                end
            end
        end
    end

    // base-p increment of the column tuple
    always_comb
    begin
        tup_wrap = 1'b1;
        for (int i = 0; i < MAX_TERMS; i++)
        begin
            tup_inc[i] = tuple_reg[i];
            if ((i < int'(p_reg)) && tup_wrap)
            begin
                if (tuple_reg[i] == CW'(p_reg - CFG_W'(1)))
                    tup_inc[i] = '0;
                else
                begin
                    tup_inc[i] = tuple_reg[i] + CW'(1);
                    tup_wrap   = 1'b0;
                end
            end
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        p_next     = p_reg;
        n_next     = n_reg;
        rep_next   = rep_reg;
        tuple_next = tuple_reg;
        row_next   = row_reg;
        prod_next  = prod_reg;
        macc_next  = macc_reg;
        mcand_next = mcand_reg;
        det_next   = det_reg;
        op_next    = op_reg;
        bit_next   = bit_reg;
        den_next   = den_reg;
        dets_we    = 1'b0;
        k_next     = k_reg;
        x_next     = x_reg;
        rem_next   = rem_reg;
        j_next     = j_reg;
        hor_next   = hor_reg;
        r_next     = r_reg;
        b_next     = b_reg;
        dd_next    = dd_reg;
        q_next     = q_reg;
        qc_next    = qc_reg;
        neg_next   = neg_reg;
        fit_next   = fit_reg;
        sing_next  = sing_reg;
        add_a      = macc_reg;
        add_b      = mcand_reg;
        add_cin    = 1'b0;
        qf         = q_reg;
        stat.done  = 1'b0;
        res_valid  = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.start)
                begin
                    p_next     = p_clamp;
                    n_next     = count;
                    rep_next   = '0;
                    state_next = S_DET_INIT;
                end
            end
            S_DET_INIT:
            begin
                det_next = '0;
                row_next = '0;
                for (int i = 0; i < MAX_TERMS; i++)
                    tuple_next[i] = '0;
                state_next = S_TUP_CHECK;
            end
            S_TUP_CHECK:
            begin
                if (perm_ok)
                begin
                    prod_next  = {{(WW-OP_W){rd_data[OP_W-1]}}, rd_data};
                    row_next   = CIW'(1);
                    hor_next   = 1'b0;
                    state_next = (p_reg == CFG_W'(1)) ? S_ACC : S_MUL_LOAD;
                end
                else
                    state_next = S_TUP_NEXT;
            end
            S_MUL_LOAD:
            begin
                mcand_next = prod_reg;
                op_next    = hor_reg ? {{(OP_W-XW){1'b0}}, x_reg} : rd_data;
                macc_next  = '0;
                bit_next   = '0;
                state_next = S_MUL_RUN;
            end
            S_MUL_RUN:
            begin
                // shift-and-add, top operand bit carries negative weight
                add_a   = macc_reg;
                add_b   = (bit_reg == BCW'(OP_W - 1)) ? ~mcand_reg : mcand_reg;
                add_cin = (bit_reg == BCW'(OP_W - 1));
                if (op_reg[0])
                    macc_next = add_sum[WW-1:0];
                mcand_next = {mcand_reg[WW-2:0], 1'b0};
                op_next    = {1'b0, op_reg[OP_W-1:1]};
                bit_next   = bit_reg + BCW'(1);
                if (bit_reg == BCW'(OP_W - 1))
                begin
                    prod_next = macc_next;
                    if (hor_reg)
                        state_next = S_HOR_ADD;
                    else
                    begin
                        row_next   = row_reg + CIW'(1);
                        state_next = (row_reg + CIW'(1) == CIW'(p_reg)) ? S_ACC : S_MUL_LOAD;
                    end
                end
            end
            S_ACC:
            begin
                add_a      = det_reg;
                add_b      = perm_odd ? ~prod_reg : prod_reg;
                add_cin    = perm_odd;
                det_next   = add_sum[WW-1:0];
                state_next = S_TUP_NEXT;
            end
            S_TUP_NEXT:
            begin
                tuple_next = tup_inc;
                row_next   = '0;
                state_next = tup_wrap ? S_DET_DONE : S_TUP_CHECK;
            end
            S_DET_DONE:
            begin
                if (rep_reg == CIW'(p_reg))
                begin
                    den_next   = det_reg;
                    k_next     = '0;
                    state_next = S_X_INIT;
                end
                else
                begin
                    dets_we    = 1'b1;
                    rep_next   = rep_reg + CIW'(1);
                    state_next = S_DET_INIT;
                end
            end
            S_X_INIT:
            begin
                x_next = '0;
                if ((p_reg == CFG_W'(1)) || (n_reg == '0))
                    state_next = S_EVAL;
                else
                begin
                    rem_next   = MW'((MW'(n_reg) - MW'(1))
                               * MW'(CFG_W'(p_reg - CFG_W'(1) - CFG_W'(k_reg))));
                    state_next = S_X_DIV;
                end
            end
            S_X_DIV:
            begin
                // repeated subtraction by p-1
                if (rem_reg >= MW'(p_reg - CFG_W'(1)))
                begin
                    rem_next = rem_reg - MW'(p_reg - CFG_W'(1));
                    x_next   = x_reg + XW'(1);
                end
                else
                    state_next = S_EVAL;
            end
            S_EVAL:
            begin
                sing_next = den_zero;
                if (den_zero)
                begin
                    fit_next   = '0;
                    state_next = S_EMIT;
                end
                else
                begin
                    prod_next  = det_rd;
                    j_next     = CIW'(p_reg - CFG_W'(1));
                    hor_next   = 1'b1;
                    state_next = (p_reg == CFG_W'(1)) ? S_ABS_NUM : S_MUL_LOAD;
                end
            end
            S_HOR_ADD:
            begin
                add_a      = prod_reg;
                add_b      = det_rd;
                add_cin    = 1'b0;
                prod_next  = add_sum[WW-1:0];
                j_next     = j_reg - CIW'(1);
                state_next = (j_reg == CIW'(1)) ? S_ABS_NUM : S_MUL_LOAD;
            end
            S_ABS_NUM:
            begin
                add_a      = prod_reg[WW-1] ? ~prod_reg : prod_reg;
                add_b      = '0;
                add_cin    = prod_reg[WW-1];
                r_next     = add_sum[WW-1:0];
                neg_next   = prod_reg[WW-1] ^ den_reg[WW-1];
                state_next = S_ABS_DEN;
            end
            S_ABS_DEN:
            begin
                add_a      = den_reg[WW-1] ? ~den_reg : den_reg;
                add_b      = '0;
                add_cin    = den_reg[WW-1];
                dd_next    = add_sum[WW-1:0];
                state_next = S_R_ADD;
            end
            S_R_ADD:
            begin
                // r = 2|num| + |den|, divisor doubled for the rounding
                add_a      = {r_reg[WW-2:0], 1'b0};
                add_b      = dd_reg;
                add_cin    = 1'b0;
                r_next     = add_sum[WW-1:0];
                dd_next    = {dd_reg[WW-2:0], 1'b0};
                b_next     = {dd_reg[WW-Q_W-1:0], {Q_W{1'b0}}};
                q_next     = '0;
                qc_next    = '0;
                state_next = S_DIV_RUN;
            end
            S_DIV_RUN:
            begin
                add_a   = r_reg;
                add_b   = ~b_reg;
                add_cin = 1'b1;
                if (add_sum[WW])
                    r_next = add_sum[WW-1:0];
                q_next  = {q_reg[Q_W-2:0], add_sum[WW]};
                b_next  = {1'b0, b_reg[WW-1:1]};
                qc_next = qc_reg + QCW'(1);
                if (qc_reg == QCW'(Q_W - 1))
                    state_next = S_DIV_CHK;
            end
            S_DIV_CHK:
            begin
                // quotient overflow, then saturate to the output range
                add_a   = r_reg;
                add_b   = ~dd_reg;
                add_cin = 1'b1;
                qf      = add_sum[WW] ? '1 : q_reg;
                if (neg_reg)
                    fit_next = (qf > Q_W'(32768)) ? FIT_W'(16'h8000) : FIT_W'(Q_W'(0) - qf);
                else
                    fit_next = (qf > Q_W'(32767)) ? FIT_W'(16'h7FFF) : qf[FIT_W-1:0];
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    if (k_reg == CIW'(p_reg - CFG_W'(1)))
                    begin
                        stat.done  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + CIW'(1);
                        state_next = S_X_INIT;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign stat.busy    = (state_reg != S_IDLE);
    assign res.fitted   = fit_reg;
    assign res.last_res = (k_reg == CIW'(p_reg - CFG_W'(1)));
    assign res.singular = sing_reg;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        p_reg     <= p_next;
        n_reg     <= n_next;
        rep_reg   <= rep_next;
        tuple_reg <= tuple_next;
        row_reg   <= row_next;
        prod_reg  <= prod_next;
        macc_reg  <= macc_next;
        mcand_reg <= mcand_next;
        det_reg   <= det_next;
        op_reg    <= op_next;
        bit_reg   <= bit_next;
        den_reg   <= den_next;
        k_reg     <= k_next;
        x_reg     <= x_next;
        rem_reg   <= rem_next;
        j_reg     <= j_next;
        hor_reg   <= hor_next;
        r_reg     <= r_next;
        b_reg     <= b_next;
        dd_reg    <= dd_next;
        q_reg     <= q_next;
        qc_reg    <= qc_next;
        neg_reg   <= neg_next;
        fit_reg   <= fit_next;
        sing_reg  <= sing_next;
        if (dets_we)
            dets_reg[rep_reg[CW-1:0]] <= det_reg;
    end

endmodule

/* design/poly_least_squares_fit_core.sv */
// ----------------------------------------------------------------------------
// poly_least_squares_fit_core
// Accumulates power sums and moments of a sample series and, on the last
// sample, emits the least-squares polynomial fit at num_terms points.
// ----------------------------------------------------------------------------
//
//  channel   direction  payload                         handshake
//  s_*       in         tdata: sample, tlast: last      tvalid/tready
//  m_*       out        tdata: fitted, tlast: last_res  tvalid/tready
//                       tuser: singular
//  cfg_*     in         wdata: num_terms                cfg_wen
//
//  each accepted sample keeps the accumulation sequencer busy while it steps
//  through the power sums and moments, and no new sample is taken before it
//  is done; a sample dropped beyond MAX_LEN leaves the sums and the count as they are.
//  the solve runs p+1 determinants on the shared wide adder: each walks p^p
//  column tuples, each permutation runs through the bit-serial multiplier
//  and each tuple that is no permutation is skipped; each result adds Horner
//  steps, a search by repeated subtraction for its evaluation point and a
//  bit-serial division.
//  reset clears the accumulators and sets num_terms to 2; s_tready stays low
//  while a sample or a solve is under way, and a stalled m_tready holds the
//  solver at its current result.
//
module poly_least_squares_fit_core
    import plsf_pkg::*;
#(
    parameter int MAX_TERMS = DEF_MAX_TERMS,
    parameter int MAX_LEN   = DEF_MAX_LEN
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wen,
    input  logic [CFG_W-1:0]    cfg_wdata,   // num_terms
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [SAMPLE_W-1:0] s_tdata,     // sample
    input  logic                s_tlast,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [FIT_W-1:0]    m_tdata,     // fitted
    output logic                m_tlast,
    output logic [0:0]          m_tuser      // singular
);

    localparam int NPOW = 2 * MAX_TERMS - 1;
    localparam int NW   = $clog2(MAX_LEN + 1);
    localparam int CW   = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int CIW  = $clog2(MAX_TERMS + 1);
    localparam int PIW  = (NPOW > 1) ? $clog2(NPOW) : 1;
    localparam int SW   = $clog2(NPOW + 1);

    logic [CFG_W-1:0]    terms_reg;
    logic [NW-1:0]       count_reg, count_next;
    logic [PS_W-1:0]     ps_reg [NPOW];
    logic [PS_W-1:0]     ps_next [NPOW];
    logic [MOM_W-1:0]    mom_reg [MAX_TERMS];
    logic [MOM_W-1:0]    mom_next [MAX_TERMS];
    logic [OP_W-1:0]     pw_reg, pw_next;
    logic [MOM_W-1:0]    mprod_reg, mprod_next;
    logic [SAMPLE_W-1:0] sv_reg;
    logic                last_reg;
    logic                do_acc_reg;
    logic                busy_reg, busy_next;
    logic [SW-1:0]       step_reg, step_next;
    logic                out_valid_reg;
    plsf_res_t           out_res_reg;

    logic                    in_acc;
    logic                    acc_end;
    logic [OP_W+NW-1:0]      pw_prod;
    logic signed [OP_W+SAMPLE_W:0] mp_prod;
    logic [SW-1:0]           mom_step;
    logic [PIW:0]            ps_addr;
    plsf_req_t               req;
    plsf_stat_t              stat;
    logic [CW-1:0]           rd_row;
    logic [CIW-1:0]          rd_col;
    logic [OP_W-1:0]         rd_data;
    plsf_res_t               res;
    logic                    res_valid, res_ready;

    // input handshake
    assign s_tready = !busy_reg && !stat.busy;
    assign in_acc   = s_tvalid && s_tready;
    assign acc_end  = busy_reg && (!do_acc_reg || (step_reg == SW'(NPOW)));

    // running power and moment product
    assign pw_prod  = pw_reg * count_reg;
    assign mp_prod  = $signed(sv_reg) * $signed({1'b0, pw_reg});
    assign mom_step = step_reg - SW'(1);

    // accumulation sequencer
    always_comb
    begin
        count_next = count_reg;
        ps_next    = ps_reg;
        mom_next   = mom_reg;
        pw_next    = pw_reg;
        mprod_next = mprod_reg;
        busy_next  = busy_reg;
        step_next  = step_reg;
        if (stat.done)
        begin
            count_next = '0;
            for (int i = 0; i < NPOW; i++)
                ps_next[i] = '0;
            for (int i = 0; i < MAX_TERMS; i++)
                mom_next[i] = '0;
        end
        if (in_acc)
        begin
            busy_next = 1'b1;
            step_next = '0;
            pw_next   = OP_W'(1);
        end
        else if (busy_reg)
        begin
            if (do_acc_reg)
            begin
                if (step_reg < SW'(NPOW))
                    ps_next[step_reg[PIW-1:0]] = ps_reg[step_reg[PIW-1:0]] + pw_reg[PS_W-1:0];
                mprod_next = mp_prod[MOM_W-1:0];
                pw_next    = pw_prod[OP_W-1:0];
                if ((step_reg >= SW'(1)) && (step_reg <= SW'(MAX_TERMS)))
                    mom_next[mom_step[CW-1:0]] = mom_reg[mom_step[CW-1:0]] + mprod_reg;
            end
            step_next = step_reg + SW'(1);
            if (acc_end)
            begin
                busy_next = 1'b0;
                if (do_acc_reg)
                    count_next = count_reg + NW'(1);
            end
        end
    end

    // solve request once the last sample is in
    assign req.start = acc_end && last_reg;
    assign req.terms = terms_reg;

    // entry of the normal matrix; the top column reads the moments
    assign ps_addr = (PIW + 1)'(rd_row) + (PIW + 1)'(rd_col);
    assign rd_data = (rd_col == CIW'(MAX_TERMS)) ? mom_reg[rd_row]
                   : {{(OP_W-PS_W){1'b0}}, ps_reg[ps_addr[PIW-1:0]]};

    // sample count including the last sample, taken with the request
    plsf_solve #(
        .MAX_TERMS (MAX_TERMS),
        .MAX_LEN   (MAX_LEN)
    ) u_solve (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .count     (count_next),
        .stat      (stat),
        .rd_row    (rd_row),
        .rd_col    (rd_col),
        .rd_data   (rd_data),
        .res       (res),
        .res_valid (res_valid),
        .res_ready (res_ready)
    );

    // output register
    assign res_ready = !out_valid_reg || m_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_res_reg.fitted;
    assign m_tlast   = out_res_reg.last_res;
    assign m_tuser   = out_res_reg.singular;

    // control state and accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            terms_reg     <= TERMS_RESET;
            count_reg     <= '0;
            busy_reg      <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NPOW; i++)
                ps_reg[i] <= '0;
            for (int i = 0; i < MAX_TERMS; i++)
                mom_reg[i] <= '0;
        end
        else
        begin
            if (cfg_wen)
                terms_reg <= cfg_wdata;
            count_reg <= count_next;
            busy_reg  <= busy_next;
            step_reg  <= step_next;
            ps_reg    <= ps_next;
            mom_reg   <= mom_next;
            if (res_valid && res_ready)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pw_reg    <= pw_next;
        mprod_reg <= mprod_next;
        if (in_acc)
        begin
            sv_reg     <= s_tdata;
            last_reg   <= s_tlast;
            do_acc_reg <= (count_reg < NW'(MAX_LEN));
        end
        if (res_valid && res_ready)
            out_res_reg <= res;
    end

endmodule

/* verif/tb_poly_least_squares_fit_core.sv */
// ----------------------------------------------------------------------------
// tb_poly_least_squares_fit_core
// Self-checking testbench of the polynomial least-squares fit core. Sample
// series are streamed in with random gaps, the fit of each series is worked
// out exactly with wide integer determinants, and every fitted value, end
// flag and singular flag from the block is compared with the oldest one due.
// ----------------------------------------------------------------------------
module tb_poly_least_squares_fit_core;
    import plsf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NTERMS   = DEF_MAX_TERMS;
    localparam int SERIES_MAX = DEF_MAX_LEN;
    localparam int NPOW     = 2 * NTERMS - 1;
    localparam int WIDE     = 352;
    localparam int LIMIT    = 30000000;

    typedef logic signed [WIDE-1:0] wide_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_wen;
    logic [CFG_W-1:0]    cfg_wdata;   // num_terms
    logic                s_tvalid;
    logic                s_tready;
    logic [SAMPLE_W-1:0] s_tdata;     // sample
    logic                s_tlast;
    logic                m_tvalid;
    logic                m_tready;
    logic [FIT_W-1:0]    m_tdata;     // fitted
    logic                m_tlast;
    logic [0:0]          m_tuser;     // singular

    // fit state mirrored by the testbench
    logic [CFG_W-1:0] fit_terms;
    int               fit_count;
    logic [PS_W-1:0]  pow_sum [NPOW];
    logic [MOM_W-1:0] moment [NTERMS];
    logic [OP_W-1:0]  normal_mat [NTERMS][NTERMS+1];

    plsf_res_t fits_due[$];

    int  errors;
    int  cycles;
    int  samples_sent;
    int  series_done;
    int  fits_seen;
    int  singular_seen;
    bit  gaps_on;
    bit  hold_on;
    int  hold_left;

    poly_least_squares_fit_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("timeout with %0d fits outstanding", fits_due.size());
            $display("tb_poly_least_squares_fit_core failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // fit predictor
    // ------------------------------------------------------------------

    // determinant of the normal matrix, column swap_col replaced by moments
    function automatic wide_t normal_det(int p, int swap_col);
        wide_t acc;
        wide_t prod;
        int    col [NTERMS];
        int    total;
        int    t;
        int    inv;
        bit    clash;
        logic signed [OP_W-1:0] e;
        acc = '0;
        total = 1;
        for (int r = 0; r < p; r++)
            total = total * p;
        for (int n = 0; n < total; n++)
        begin
            t = n;
            for (int r = 0; r < p; r++)
            begin
                col[r] = t % p;
                t = t / p;
            end
            clash = 0;
            inv = 0;
            for (int r = 0; r < p; r++)
                for (int s = r + 1; s < p; s++)
                begin
                    if (col[r] == col[s])
                        clash = 1;
                    if (col[r] > col[s])
                        inv++;
                end
            if (!clash)
            begin
                prod = 1;
                for (int r = 0; r < p; r++)
                begin
                    e = $signed(normal_mat[r][col[r] == swap_col ? NTERMS : col[r]]);
                    prod = prod * e;
                end
                if (inv % 2)
                    acc = acc - prod;
                else
                    acc = acc + prod;
            end
        end
        return acc;
    endfunction

    // round to nearest, ties away from zero, then saturate to q1.15
    function automatic logic [FIT_W-1:0] round_ratio(wide_t num, wide_t den);
        logic [WIDE+7:0] a;
        logic [WIDE+7:0] d;
        logic [WIDE+7:0] q;
        bit              neg;
        int              v;
        neg = num[WIDE-1] != den[WIDE-1];
        a = num[WIDE-1] ? WIDE'(-num) : WIDE'(num);
        d = den[WIDE-1] ? WIDE'(-den) : WIDE'(den);
        q = (2 * a + d) / (2 * d);
        if (neg)
            v = (q > 32768) ? -32768 : -int'(q);
        else
            v = (q > 32767) ? 32767 : int'(q);
        return v[FIT_W-1:0];
    endfunction

    // solve the normal equations and queue the fitted values
    task automatic solve_fit();
        int        p;
        wide_t     den;
        wide_t     num [NTERMS];
        wide_t     acc;
        wide_t     xp;
        int        x;
        plsf_res_t r;
        p = (fit_terms == 0) ? 1 : (fit_terms > NTERMS ? NTERMS : int'(fit_terms));
        for (int a = 0; a < p; a++)
        begin
            for (int b = 0; b < p; b++)
                normal_mat[a][b] = {{(OP_W-PS_W){1'b0}}, pow_sum[a+b]};
            normal_mat[a][NTERMS] = moment[a];
        end
        den = normal_det(p, NTERMS + 1);
        for (int j = 0; j < p; j++)
            num[j] = normal_det(p, j);
        for (int k = 0; k < p; k++)
        begin
            x = 0;
            if (p > 1 && fit_count > 0)
                x = ((fit_count - 1) * (p - 1 - k)) / (p - 1);
            r.fitted = '0;
            if (den != 0)
            begin
                acc = '0;
                xp = 1;
                for (int j = 0; j < p; j++)
                begin
                    acc = acc + num[j] * xp;
                    xp = xp * x;
                end
                r.fitted = round_ratio(acc, den);
            end
            r.last_res = (k == p - 1);
            r.singular = (den == 0);
            fits_due.push_back(r);
        end
        fit_count = 0;
        for (int k = 0; k < NPOW; k++)
            pow_sum[k] = '0;
        for (int k = 0; k < NTERMS; k++)
            moment[k] = '0;
        series_done++;
    endtask

    // fold one accepted sample into the sums
    task automatic accumulate_sample(logic [SAMPLE_W-1:0] smp, logic fin);
        logic signed [MOM_W-1:0] sv;
        logic [MOM_W-1:0]        pw;
        sv = $signed(smp);
        if (fit_count < SERIES_MAX)
        begin
            pw = 1;
            for (int k = 0; k < NPOW; k++)
            begin
                pow_sum[k] = pow_sum[k] + pw[PS_W-1:0];
                if (k < NTERMS)
                    moment[k] = moment[k] + sv * pw;
                pw = pw * fit_count;
            end
            fit_count++;
        end
        if (fin)
            solve_fit();
    endtask

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(string what, int got, int want);
        errors++;
        $display("mismatch %s: got %0d expected %0d (fit %0d)", what, got, want, fits_seen);
    endtask

    // long receiver hold, counted down in cycles
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_on <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else
            hold_on <= 1'b0;
    end

    // receiver: check each transaction, stall in random bursts
    int stall_left;
    always @(posedge clk or negedge rst_n)
    begin
        plsf_res_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (fits_due.size() == 0)
                begin
                    errors++;
                    $display("unexpected fit transaction, fitted %0d", $signed(m_tdata));
                end
                else
                begin
                    want = fits_due.pop_front();
                    if (m_tdata !== want.fitted)
                        report_mismatch("fitted", $signed(m_tdata), $signed(want.fitted));
                    if (m_tlast !== want.last_res)
                        report_mismatch("last", m_tlast, want.last_res);
                    if (m_tuser[0] !== want.singular)
                        report_mismatch("singular", m_tuser[0], want.singular);
                    if (want.singular)
                        singular_seen++;
                end
                fits_seen++;
            end
            if (stall_left > 0)
                stall_left--;
            else if (gaps_on && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 10);
            m_tready <= !(hold_on || hold_left > 0 || stall_left > 0);
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // offer one sample and wait for its transaction
    task automatic send_sample(int value, bit fin);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value[SAMPLE_W-1:0];
        s_tlast  <= fin;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        accumulate_sample(value[SAMPLE_W-1:0], fin);
        samples_sent++;
    endtask

    // drop valid and wait for every fit, then a settling margin
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (fits_due.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_terms(int value);
        wait_idle();
        cfg_wen   <= 1'b1;
        cfg_wdata <= value[CFG_W-1:0];
        @(posedge clk);
        fit_terms = value[CFG_W-1:0];
        cfg_wen   <= 1'b0;
    endtask

    function automatic int clip16(int v);
        return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
    endfunction

    // one series of the given length and shape
    task automatic send_series(int len, int shape);
        int base;
        int slope;
        int curve;
        int v;
        base  = $urandom_range(0, 65535) - 32768;
        slope = $urandom_range(0, 4000) - 2000;
        curve = $urandom_range(0, 200) - 100;
        for (int i = 0; i < len; i++)
        begin
            case (shape)
                0: v = $urandom_range(0, 65535) - 32768;
                1: v = clip16(base + slope * i + curve * i * i
                              + $urandom_range(0, 64) - 32);
                2: v = base;
                default: v = (i % 2) ? 32767 : -32768;
            endcase
            send_sample(v, i == len - 1);
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // straight line at the reset setting, full-scale samples
    task automatic test_reset_terms();
        send_sample(0, 0);
        send_sample(32767, 0);
        send_sample(-32768, 1);
        send_sample(-32768, 0);
        send_sample(32767, 1);
    endtask

    // one term gives the mean, including a single sample
    task automatic test_mean();
        write_terms(1);
        send_sample(32767, 1);
        send_sample(-32768, 1);
        send_sample(1, 0);
        send_sample(2, 1);
        send_sample(-1, 0);
        send_sample(-2, 1);
    endtask

    // fewer samples than terms, and full-scale zig-zag at four terms
    task automatic test_singular();
        write_terms(4);
        send_sample(1000, 0);
        send_sample(-1000, 1);
        write_terms(3);
        send_sample(-32768, 1);
        write_terms(4);
        send_series(6, 3);
    endtask

    // out-of-range settings are clamped
    task automatic test_terms_clamp();
        write_terms(0);
        send_series(3, 1);
        write_terms(5);
        send_series(5, 1);
        write_terms(7);
        send_series(4, 0);
    endtask

    // series longer than the accumulator window, and one that just fills it
    task automatic test_overflow();
        write_terms(3);
        send_series(SERIES_MAX + 6, 1);
        write_terms(2);
        send_series(SERIES_MAX, 0);
    endtask

    // receiver holds off while short series keep coming
    task automatic test_backpressure();
        write_terms(2);
        hold_left = 3000;
        for (int i = 0; i < 6; i++)
            send_series($urandom_range(1, 3), 0);
        wait_idle();
    endtask

    // random series, with fresh settings between some of them
    task automatic test_random(int quota);
        int start;
        start = samples_sent;
        while (samples_sent - start < quota)
        begin
            if ($urandom_range(0, 2) == 0)
                write_terms($urandom_range(0, 7));
            if ($urandom_range(0, 12) == 0)
                send_series($urandom_range(SERIES_MAX - 2, SERIES_MAX + 3),
                            $urandom_range(0, 3));
            else
                send_series($urandom_range(1, 16), $urandom_range(0, 3));
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_wen   = 1'b0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        errors    = 0;
        cycles    = 0;
        samples_sent  = 0;
        series_done   = 0;
        fits_seen     = 0;
        singular_seen = 0;
        hold_left = 0;
        hold_on   = 1'b0;
        gaps_on   = 1'b1;
        fit_terms = TERMS_RESET;
        fit_count = 0;
        for (int k = 0; k < NPOW; k++)
            pow_sum[k] = '0;
        for (int k = 0; k < NTERMS; k++)
            moment[k] = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_terms();
        test_mean();
        test_singular();
        test_terms_clamp();
        test_overflow();
        test_backpressure();
        test_random(20);
        wait_idle();
        gaps_on = 1'b0;
        test_random(10);
        wait_idle();

        $display("covered %0d samples in %0d series, %0d fits checked (%0d singular)",
                 samples_sent, series_done, fits_seen, singular_seen);
        $display("terms settings 0..7, window overflow, long output hold and idle gaps");
        if (errors == 0)
            $display("tb_poly_least_squares_fit_core passed");
        else
            $display("tb_poly_least_squares_fit_core failed");
        $finish;
    end

endmodule

/* poly_least_squares_fit_core.f */
design/plsf_pkg.sv
design/plsf_solve.sv
design/poly_least_squares_fit_core.sv
verif/tb_poly_least_squares_fit_core.sv
